### design/rct_pkg.sv
// Shared types and constants for the address reference-count table.
// Used by rct_hash, rct_bucket_mem and address_refcount_table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

   localparam int ADDR_W = 64;
   localparam int COUNT_W = 32;
   localparam int CFG_W = 13;

   localparam int DEFAULT_NUM_BUCKETS = 1024;
   localparam int DEFAULT_WAYS = 4;

   localparam logic [ADDR_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
   localparam int HASH_SHIFT = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd3072;

   localparam logic CMD_INC = 1'b0;
   localparam logic CMD_DEC = 1'b1;

   typedef enum logic [1:0] {
      STATUS_COUNTED   = 2'd0,
      STATUS_REMOVED   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_NO_ROOM   = 2'd3
   } status_type;

endpackage

`default_nettype wire

### design/address_refcount_table.sv
// Reference counts for physical addresses in a set-associative table of
// NUM_BUCKETS buckets by WAYS ways. Each req item (increment or decrement
// of one address) yields one rsp item with the new count and a status. After
// reset the block clears all NUM_BUCKETS buckets (1024 at default size),
// one bucket a cycle, with req_stall high; csr writes are taken at any time.
// An accepted req item goes through the hash multiply on one 32x32
// multiplier, the remainder by the bucket count (reciprocal multiply, back
// multiply and one correcting subtract on the same multiplier), one bucket
// memory read, one way compare and a write-back step, and its rsp item is
// then registered in the output register. One item is in work at a time, so
// no req item is accepted until the last one has left write-back; a finished
// rsp item may wait in the output register while the next item is accepted
// and hashed, and while it waits the next item holds in write-back.
`timescale 1ns / 1ps
`default_nettype none

module address_refcount_table #(
   parameter int NUM_BUCKETS = rct_pkg::DEFAULT_NUM_BUCKETS,
   parameter int WAYS = rct_pkg::DEFAULT_WAYS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_command,
   input  wire logic [rct_pkg::ADDR_W-1:0]    req_address,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rct_pkg::COUNT_W-1:0]        rsp_count,
   output logic [1:0]                         rsp_status,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rct_pkg::CFG_W-1:0]     csr_max_live_entries
);

   localparam int BKT_W = $clog2(NUM_BUCKETS);
   localparam int SLOTS = NUM_BUCKETS * WAYS;
   localparam int LIVE_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (LIVE_W > rct_pkg::CFG_W) ? LIVE_W : rct_pkg::CFG_W;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ADDR_W = rct_pkg::ADDR_W;
   localparam int COUNT_W = rct_pkg::COUNT_W;
   localparam int ROW_W = WAYS * (1 + ADDR_W + COUNT_W);
   localparam int CNT_BASE = WAYS + WAYS * ADDR_W;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_HASH   = 5'b00100,
      S_SEARCH = 5'b01000,
      S_UPDATE = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [BKT_W-1:0]             clear_idx_ff, clear_idx_in;
   logic [LIVE_W-1:0]            live_ff, live_in;
   logic [rct_pkg::CFG_W-1:0]    max_live_ff, max_live_in;
   logic                         cmd_ff, cmd_in;
   logic [ADDR_W-1:0]            addr_ff, addr_in;
   logic [BKT_W-1:0]             bucket_ff, bucket_in;

   logic                         hit_ff, hit_in;
   logic [WAY_W-1:0]             hit_way_ff, hit_way_in;
   logic [COUNT_W-1:0]           hit_cnt_ff, hit_cnt_in;
   logic                         free_ff, free_in;
   logic [WAY_W-1:0]             free_way_ff, free_way_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic                         out_free;
   logic                         advance;
   logic                         hash_done;
   logic [BKT_W-1:0]             hash_bucket;

   logic                         mem_wr_en;
   logic [BKT_W-1:0]             mem_wr_bucket;
   logic [ROW_W-1:0]             mem_wr_row;
   logic [ROW_W-1:0]             rd_row;

   logic [WAYS-1:0]              row_valid;
   logic [ADDR_W-1:0]            row_addr [WAYS];
   logic [COUNT_W-1:0]           row_cnt [WAYS];

   logic                         live_full;
   logic                         upd_write;
   logic                         upd_valid;
   logic [WAY_W-1:0]             upd_way;
   logic [COUNT_W-1:0]           upd_cnt;
   logic [ROW_W-1:0]             upd_row;
   logic [LIVE_W-1:0]            upd_live;
   logic [COUNT_W-1:0]           upd_count;
   rct_pkg::status_type          upd_status;

   rct_hash #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .address (req_address),
      .done    (hash_done),
      .bucket  (hash_bucket)
   );

   rct_bucket_mem #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .WAYS       (WAYS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_bucket (mem_wr_bucket),
      .wr_row    (mem_wr_row),
      .rd_en     (hash_done),
      .rd_bucket (hash_bucket),
      .rd_row    (rd_row)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = (state_ff == S_UPDATE) && out_free;
   assign csr_ready = 1'b1;

   // unpack the bucket row
   always_comb begin
      row_valid = rd_row[WAYS-1:0];
      for (int w = 0; w < WAYS; w++) begin
         row_addr[w] = rd_row[WAYS + w*ADDR_W +: ADDR_W];
         row_cnt[w] = rd_row[CNT_BASE + w*COUNT_W +: COUNT_W];
      end
   end

   // way search: first matching way and first free way
   always_comb begin
      hit_in = 1'b0;
      hit_way_in = '0;
      hit_cnt_in = '0;
      free_in = 1'b0;
      free_way_in = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_valid[w]) begin
            if (!hit_in && (row_addr[w] == addr_ff)) begin
               hit_in = 1'b1;
               hit_way_in = WAY_W'(w);
               hit_cnt_in = row_cnt[w];
            end
         end else if (!free_in) begin
            free_in = 1'b1;
            free_way_in = WAY_W'(w);
         end
      end
   end

   assign live_full = (CMP_W'(live_ff) >= CMP_W'(max_live_ff));

   // count update and row write-back
   always_comb begin
      upd_write = 1'b0;
      upd_valid = 1'b1;
      upd_way = hit_way_ff;
      upd_cnt = '0;
      upd_live = live_ff;
      upd_count = '0;
      upd_status = rct_pkg::STATUS_NO_ROOM;
      case (cmd_ff)
         rct_pkg::CMD_INC: begin
            if (hit_ff) begin
               upd_cnt = (hit_cnt_ff == rct_pkg::COUNT_MAX) ? rct_pkg::COUNT_MAX
                                                            : hit_cnt_ff + COUNT_W'(1);
               upd_write = 1'b1;
               upd_count = upd_cnt;
               upd_status = rct_pkg::STATUS_COUNTED;
            end else if (!free_ff || live_full) begin
               upd_status = rct_pkg::STATUS_NO_ROOM;
            end else begin
               upd_way = free_way_ff;
               upd_cnt = COUNT_W'(1);
               upd_write = 1'b1;
               upd_live = live_ff + LIVE_W'(1);
               upd_count = upd_cnt;
               upd_status = rct_pkg::STATUS_COUNTED;
            end
         end
         rct_pkg::CMD_DEC: begin
            if (!hit_ff) begin
               upd_status = rct_pkg::STATUS_NOT_FOUND;
            end else if (hit_cnt_ff <= COUNT_W'(1)) begin
               upd_valid = 1'b0;
               upd_write = 1'b1;
               if (live_ff != '0) begin
                  upd_live = live_ff - LIVE_W'(1);
               end
               upd_status = rct_pkg::STATUS_REMOVED;
            end else begin
               upd_cnt = hit_cnt_ff - COUNT_W'(1);
               upd_write = 1'b1;
               upd_count = upd_cnt;
               upd_status = rct_pkg::STATUS_COUNTED;
            end
         end
         default: begin
            upd_write = 1'b0;
         end
      endcase
      upd_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == upd_way) begin
            upd_row[w] = upd_valid;
            upd_row[WAYS + w*ADDR_W +: ADDR_W] = addr_ff;
            upd_row[CNT_BASE + w*COUNT_W +: COUNT_W] = upd_cnt;
         end
      end
   end

   always_comb begin
      mem_wr_en = (state_ff == S_CLEAR) || (advance && upd_write);
      mem_wr_bucket = (state_ff == S_CLEAR) ? clear_idx_ff : bucket_ff;
      mem_wr_row = (state_ff == S_CLEAR) ? '0 : upd_row;
   end

   always_comb begin
      state_in = state_ff;
      clear_idx_in = clear_idx_ff;
      live_in = live_ff;
      max_live_in = max_live_ff;
      cmd_in = cmd_ff;
      addr_in = addr_ff;
      bucket_in = bucket_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (csr_valid && csr_ready) begin
         max_live_in = csr_max_live_entries;
      end
      case (state_ff)
         S_CLEAR: begin
            clear_idx_in = clear_idx_ff + BKT_W'(1);
            if (clear_idx_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               addr_in = req_address;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               live_in = upd_live;
               rsp_valid_in = 1'b1;
               rsp_count_in = upd_count;
               rsp_status_in = upd_status;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_idx_ff <= '0;
         live_ff <= '0;
         max_live_ff <= rct_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clear_idx_ff <= clear_idx_in;
         live_ff <= live_in;
         max_live_ff <= max_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      addr_ff <= addr_in;
      bucket_ff <= bucket_in;
      rsp_count_ff <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      if (state_ff == S_SEARCH) begin
         hit_ff <= hit_in;
         hit_way_ff <= hit_way_in;
         hit_cnt_ff <= hit_cnt_in;
         free_ff <= free_in;
         free_way_ff <= free_way_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

### design/rct_hash.sv
// Bucket hash: golden-ratio multiply on one shared 32x32 multiplier, then the
// remainder by the bucket count through a reciprocal multiply on the same unit.
// Depends on rct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rct_hash #(
   parameter int NUM_BUCKETS = rct_pkg::DEFAULT_NUM_BUCKETS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [rct_pkg::ADDR_W-1:0]        address,
   output logic                                   done,
   output logic [$clog2(NUM_BUCKETS)-1:0]         bucket
);

   localparam int BKT_W = $clog2(NUM_BUCKETS);
   localparam int HALF = rct_pkg::HASH_SHIFT;
   localparam logic [HALF-1:0] RECIP = HALF'((64'd1 << HALF) / NUM_BUCKETS);
   localparam logic [HALF-1:0] DIVISOR = HALF'(NUM_BUCKETS);

   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_LO_HI = 2'd1;
   localparam logic [1:0] MUL_HI_LO = 2'd2;

   typedef enum logic [6:0] {
      H_IDLE = 7'b0000001,
      H_MUL  = 7'b0000010,
      H_ACC  = 7'b0000100,
      H_QUO  = 7'b0001000,
      H_REM  = 7'b0010000,
      H_FIX  = 7'b0100000,
      H_DONE = 7'b1000000
   } hash_state_type;

   hash_state_type                 state_ff, state_in;
   logic [rct_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [1:0]                     sel_ff, sel_in;
   logic [2*HALF-1:0]              prod_ff, prod_in;
   logic [HALF-1:0]                acc_ff, acc_in;
   logic [BKT_W-1:0]               rem_ff, rem_in;

   logic [HALF-1:0]                a_op;
   logic [HALF-1:0]                m_op;
   logic [HALF-1:0]                term;
   logic [HALF-1:0]                mul_a;
   logic [HALF-1:0]                mul_b;
   logic [2*HALF-1:0]              mul_p;
   logic [HALF-1:0]                diff;
   logic [HALF-1:0]                fixed;

   always_comb begin
      a_op = (sel_ff == MUL_HI_LO) ? addr_ff[2*HALF-1:HALF] : addr_ff[HALF-1:0];
      m_op = (sel_ff == MUL_LO_HI) ? rct_pkg::HASH_MULT[2*HALF-1:HALF]
                                   : rct_pkg::HASH_MULT[HALF-1:0];
      term = (sel_ff == MUL_LO_LO) ? prod_ff[2*HALF-1:HALF] : prod_ff[HALF-1:0];
      // shared multiplier operands
      case (state_ff)
         H_QUO: begin
            mul_a = acc_ff;
            mul_b = RECIP;
         end
         H_REM: begin
            mul_a = prod_ff[2*HALF-1:HALF];
            mul_b = DIVISOR;
         end
         default: begin
            mul_a = a_op;
            mul_b = m_op;
         end
      endcase
      mul_p = (2*HALF)'(mul_a) * (2*HALF)'(mul_b);
      // quotient estimate is low by at most one
      diff = acc_ff - prod_ff[HALF-1:0];
      fixed = (diff >= DIVISOR) ? diff - DIVISOR : diff;
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      sel_in = sel_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               addr_in = address;
               sel_in = MUL_LO_LO;
               acc_in = '0;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            prod_in = mul_p;
            state_in = H_ACC;
         end
         H_ACC: begin
            acc_in = acc_ff + term;
            sel_in = sel_ff + 2'd1;
            if (sel_ff == MUL_HI_LO) begin
               state_in = H_QUO;
            end else begin
               state_in = H_MUL;
            end
         end
         H_QUO: begin
            prod_in = mul_p;
            state_in = H_REM;
         end
         H_REM: begin
            prod_in = mul_p;
            state_in = H_FIX;
         end
         H_FIX: begin
            rem_in = fixed[BKT_W-1:0];
            state_in = H_DONE;
         end
         H_DONE: begin
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      addr_ff <= addr_in;
      sel_ff <= sel_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done = (state_ff == H_DONE);
   assign bucket = rem_ff;

endmodule

`default_nettype wire

### design/rct_bucket_mem.sv
// Bucket memory: one row per bucket holding valid bits, addresses and counts
// of all ways. One write and one registered read port. Depends on rct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rct_bucket_mem #(
   parameter int NUM_BUCKETS = rct_pkg::DEFAULT_NUM_BUCKETS,
   parameter int WAYS = rct_pkg::DEFAULT_WAYS
) (
   input  wire logic                                                  clock,
   input  wire logic                                                  wr_en,
   input  wire logic [$clog2(NUM_BUCKETS)-1:0]                        wr_bucket,
   input  wire logic [WAYS*(1+rct_pkg::ADDR_W+rct_pkg::COUNT_W)-1:0]  wr_row,
   input  wire logic                                                  rd_en,
   input  wire logic [$clog2(NUM_BUCKETS)-1:0]                        rd_bucket,
   output logic [WAYS*(1+rct_pkg::ADDR_W+rct_pkg::COUNT_W)-1:0]       rd_row
);

   localparam int ROW_W = WAYS * (1 + rct_pkg::ADDR_W + rct_pkg::COUNT_W);

   logic [ROW_W-1:0] mem [NUM_BUCKETS];
   logic [ROW_W-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_bucket] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_bucket];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

`default_nettype wire
